[rtl/hrc_pkg.sv]
// Shared constants, register codes and types of the hysteresis relay controller.
`default_nettype none

package hrc_pkg;

  localparam int SAMPLES_DEFAULT = 10;
  localparam int ADC_W           = 10;
  localparam int ADC_MAX         = (1 << ADC_W) - 1;
  localparam int CAL_W           = 24;
  localparam int BAND_W          = 23;
  localparam int DWELL_W         = 16;
  localparam int GAIN_W          = 16;
  localparam int TICK_W          = 17;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 24;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CAL_MAX         = 8388607;
  localparam int CAL_MIN         = -8388608;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT      = 4'd0,
    CFG_UPPER_BAND    = 4'd1,
    CFG_LOWER_BAND    = 4'd2,
    CFG_DIRECT_MODE   = 4'd3,
    CFG_MIN_DWELL     = 4'd4,
    CFG_GAIN          = 4'd5,
    CFG_OFFSET        = 4'd6,
    CFG_INITIAL_RELAY = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CAL_W-1:0]  setpoint;
    logic        [BAND_W-1:0] upper_band;
    logic        [BAND_W-1:0] lower_band;
    logic                     direct_mode;
    logic        [DWELL_W-1:0] min_dwell;
    logic signed [GAIN_W-1:0] gain;
    logic signed [CAL_W-1:0]  offset;
    logic                     relay_load;
    logic                     relay_value;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/hysteresis_relay_controller.sv]
// Top level of the hysteresis relay controller: registers, front end, queue and back end.
//
// Usage:
//   Input channel (in_valid / in_stall): each transfer is either a converter sample
//   (in_func = 0, reading on in_adc_sample) or a one-millisecond tick (in_func = 1).
//   One item is taken per clock cycle; in_stall rises only when the four-entry work
//   queue is full, which happens only while the result side stalls.
//   Every SAMPLES_PER_DECISION samples form one decision; ticks and partial groups
//   give no result. The result (relay_on, switched, calibrated_value) shows on the
//   out_ channel once the sample that closes the group has passed through the queue,
//   the calibration stages and the hysteresis decision into the output register.
//   A stall on out_stall while a result is valid freezes the back-end pipeline; the
//   front keeps filling the queue until it is full, then stalls the input.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready and
//   takes effect on the next cycle; write it only while no result is pending.
//   Writing initial_relay loads the relay state at once.
//   Reset (rst_n low, synchronous) clears the sample group, the tick counter, the
//   queue and the pipeline, sets the relay off and loads register defaults.
`default_nettype none

module hysteresis_relay_controller #(
  parameter int SAMPLES_PER_DECISION = hrc_pkg::SAMPLES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [hrc_pkg::ADC_W-1:0]         in_adc_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_relay_on,
  output logic                              out_switched,
  output logic signed [hrc_pkg::CAL_W-1:0]  out_calibrated_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hrc_pkg::*;

  localparam int SUM_W = $clog2(SAMPLES_PER_DECISION * ADC_MAX + 1);
  localparam int ENT_W = SUM_W + 1;

  // Configuration registers.
  logic signed [CAL_W-1:0]   setpoint_r;
  logic        [BAND_W-1:0]  upper_band_r;
  logic        [BAND_W-1:0]  lower_band_r;
  logic                      direct_mode_r;
  logic        [DWELL_W-1:0] min_dwell_r;
  logic signed [GAIN_W-1:0]  gain_r;
  logic signed [CAL_W-1:0]   offset_r;

  logic       cfg_wr;
  logic       relay_load;
  cfg_t       cfg;

  logic             push;
  logic [ENT_W-1:0] push_data;
  logic             pop;
  logic [ENT_W-1:0] queue_head;
  logic             queue_full;
  logic             queue_empty;

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign relay_load = cfg_wr && (cfg_idx_t'(cfg_index) == CFG_INITIAL_RELAY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r    <= '0;
      upper_band_r  <= '0;
      lower_band_r  <= '0;
      direct_mode_r <= 1'b1;
      min_dwell_r   <= '0;
      gain_r        <= GAIN_W'(256);
      offset_r      <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SETPOINT:    setpoint_r    <= cfg_data[CAL_W-1:0];
        CFG_UPPER_BAND:  upper_band_r  <= cfg_data[BAND_W-1:0];
        CFG_LOWER_BAND:  lower_band_r  <= cfg_data[BAND_W-1:0];
        CFG_DIRECT_MODE: direct_mode_r <= cfg_data[0];
        CFG_MIN_DWELL:   min_dwell_r   <= cfg_data[DWELL_W-1:0];
        CFG_GAIN:        gain_r        <= cfg_data[GAIN_W-1:0];
        CFG_OFFSET:      offset_r      <= cfg_data[CAL_W-1:0];
        // initial_relay goes straight to the relay state in the back end
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.setpoint    = setpoint_r;
    cfg.upper_band  = upper_band_r;
    cfg.lower_band  = lower_band_r;
    cfg.direct_mode = direct_mode_r;
    cfg.min_dwell   = min_dwell_r;
    cfg.gain        = gain_r;
    cfg.offset      = offset_r;
    cfg.relay_load  = relay_load;
    cfg.relay_value = cfg_data[0];
  end

  hrc_front #(
    .SAMPLES_PER_DECISION(SAMPLES_PER_DECISION)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_adc_sample(in_adc_sample),
    .queue_full   (queue_full),
    .push         (push),
    .push_data    (push_data)
  );

  hrc_queue #(
    .W    (ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(push_data),
    .pop  (pop),
    .rdata(queue_head),
    .full (queue_full),
    .empty(queue_empty)
  );

  hrc_back #(
    .SAMPLES_PER_DECISION(SAMPLES_PER_DECISION)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .entry               (queue_head),
    .queue_empty         (queue_empty),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_relay_on        (out_relay_on),
    .out_switched        (out_switched),
    .out_calibrated_value(out_calibrated_value)
  );

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // A tick transfer always lands in the queue; nothing can drain it in the same cycle.
  a_tick_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_func == FUNC_TICK)) |=> !queue_empty)
    else $error("accepted tick missing from work queue");

endmodule

`default_nettype wire

[rtl/hrc_front.sv]
// Front end: accepts samples and ticks, accumulates sample groups, pushes work entries.
`default_nettype none

module hrc_front #(
  parameter int SAMPLES_PER_DECISION = hrc_pkg::SAMPLES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [hrc_pkg::ADC_W-1:0]  in_adc_sample,
  input  logic                       queue_full,
  output logic                       push,
  output logic [$clog2(SAMPLES_PER_DECISION*hrc_pkg::ADC_MAX+1):0] push_data
);
  import hrc_pkg::*;

  localparam int N     = SAMPLES_PER_DECISION;
  localparam int SUM_W = $clog2(N * ADC_MAX + 1);
  localparam int CNT_W = (N > 1) ? $clog2(N) : 1;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             take;
  logic             last;
  logic [SUM_W-1:0] sum_add;

  assign in_stall = queue_full;
  assign take     = in_valid && !queue_full;
  assign sum_add  = sum_r + SUM_W'(in_adc_sample);
  assign last     = (cnt_r == CNT_W'(N - 1));

  // A tick always goes back; a sample only when it closes a group.
  assign push      = take && ((in_func == FUNC_TICK) || last);
  assign push_data = {in_func == FUNC_TICK, sum_add};

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (take && (in_func == FUNC_SAMPLE)) begin
      if (last) begin
        cnt_nxt = '0;
        sum_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        sum_nxt = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/hrc_queue.sv]
// Short first-in first-out queue between the front end and the back end.
`default_nettype none

module hrc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = hrc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  import hrc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/hrc_back.sv]
// Back end: calibration pipeline, hysteresis decision, dwell counter and output register.
`default_nettype none

module hrc_back #(
  parameter int SAMPLES_PER_DECISION = hrc_pkg::SAMPLES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hrc_pkg::cfg_t                cfg,
  input  logic [$clog2(SAMPLES_PER_DECISION*hrc_pkg::ADC_MAX+1):0] entry,
  input  logic                         queue_empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_relay_on,
  output logic                         out_switched,
  output logic signed [hrc_pkg::CAL_W-1:0] out_calibrated_value
);
  import hrc_pkg::*;

  localparam int N     = SAMPLES_PER_DECISION;
  localparam int SUM_W = $clog2(N * ADC_MAX + 1);
  localparam int PW    = GAIN_W + SUM_W + 1;
  localparam int MW    = PW;
  localparam int VW    = MW + 2;
  localparam int TW    = CAL_W + 1;
  localparam logic [64:0] RECIP_WIDE = (65'd1 << MW) / 65'(N);
  localparam logic [MW:0] RECIP = RECIP_WIDE[MW:0];
  localparam logic [MW-1:0] HALF = MW'(N / 2);
  localparam logic [MW-1:0] NV   = MW'(N);
  localparam logic signed [VW-1:0] SAT_HI = VW'(CAL_MAX);
  localparam logic signed [VW-1:0] SAT_LO = VW'(CAL_MIN);
  localparam logic [TICK_W-1:0] TICK_SAT = '1;

  logic adv;

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                    t1_r, t2_r, t3_r, t4_r, t5_r;
  logic                    neg2_r, neg3_r, neg4_r;
  logic signed [PW-1:0]    p1_r;
  logic [MW-1:0]           m2_r, m3_r;
  logic [MW-1:0]           q3_r, q4_r;
  logic signed [CAL_W-1:0] cal5_r;

  logic                    out_valid_r;
  logic                    out_relay_r;
  logic                    out_switched_r;
  logic signed [CAL_W-1:0] out_cal_r;
  logic                    relay_r, relay_nxt;
  logic [TICK_W-1:0]       ticks_r, ticks_nxt;

  logic signed [PW-1:0]    prod1;
  logic [PW-1:0]           abs2;
  logic [2*MW:0]           prod3;
  logic [MW-1:0]           qn4, rem4, q4;
  logic signed [VW-1:0]    qs5, sum5, sat5;
  logic signed [TW-1:0]    lo_thr, hi_thr, cal_ext;
  logic                    may, at_low, at_high, sw;

  // The whole pipe moves as one; it freezes only while a result waits.
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && !queue_empty;

  assign prod1 = PW'(cfg.gain) * $signed({{(PW - SUM_W){1'b0}}, entry[SUM_W-1:0]});
  assign abs2  = p1_r[PW-1] ? PW'(-p1_r) : PW'(p1_r);
  assign prod3 = (2*MW+1)'(m2_r) * (2*MW+1)'(RECIP);

  // Reciprocal estimate is low by at most one; fix it with one compare.
  assign qn4  = q3_r * NV;
  assign rem4 = m3_r - qn4;
  assign q4   = (rem4 >= NV) ? q3_r + MW'(1) : q3_r;

  assign qs5  = neg4_r ? -$signed(VW'(q4_r)) : $signed(VW'(q4_r));
  assign sum5 = qs5 + VW'(cfg.offset);
  assign sat5 = (sum5 > SAT_HI) ? SAT_HI : ((sum5 < SAT_LO) ? SAT_LO : sum5);

  assign lo_thr  = TW'(cfg.setpoint) - $signed({2'b00, cfg.lower_band});
  assign hi_thr  = TW'(cfg.setpoint) + $signed({2'b00, cfg.upper_band});
  assign cal_ext = TW'(cal5_r);
  assign at_low  = (cal_ext <= lo_thr);
  assign at_high = (cal_ext >= hi_thr);
  assign may     = (ticks_r > TICK_W'(cfg.min_dwell));

  always_comb begin
    if (!relay_r) begin
      sw = may && (cfg.direct_mode ? at_low : at_high);
    end else begin
      sw = may && (cfg.direct_mode ? at_high : at_low);
    end
  end

  always_comb begin
    relay_nxt = relay_r;
    ticks_nxt = ticks_r;
    if (adv && v5_r) begin
      if (t5_r) begin
        if (ticks_r != TICK_SAT) ticks_nxt = ticks_r + TICK_W'(1);
      end else if (sw) begin
        relay_nxt = !relay_r;
        ticks_nxt = '0;
      end
    end
    if (cfg.relay_load) relay_nxt = cfg.relay_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
      relay_r     <= 1'b0;
      ticks_r     <= '0;
    end else begin
      relay_r <= relay_nxt;
      ticks_r <= ticks_nxt;
      if (adv) begin
        v1_r        <= pop;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        v4_r        <= v3_r;
        v5_r        <= v4_r;
        out_valid_r <= v5_r && !t5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r   <= entry[SUM_W];
      p1_r   <= prod1;
      t2_r   <= t1_r;
      neg2_r <= p1_r[PW-1];
      m2_r   <= MW'(abs2) + HALF;
      t3_r   <= t2_r;
      neg3_r <= neg2_r;
      m3_r   <= m2_r;
      q3_r   <= prod3[MW +: MW];
      t4_r   <= t3_r;
      neg4_r <= neg3_r;
      q4_r   <= q4;
      t5_r   <= t4_r;
      cal5_r <= sat5[CAL_W-1:0];
      if (v5_r && !t5_r) begin
        out_relay_r    <= sw ? !relay_r : relay_r;
        out_switched_r <= sw;
        out_cal_r      <= cal5_r;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_relay_on         = out_relay_r;
  assign out_switched         = out_switched_r;
  assign out_calibrated_value = out_cal_r;

endmodule

`default_nettype wire

[dv/tb_hysteresis_relay_controller.sv]
// Self-checking testbench for the hysteresis relay controller: directed and random traffic.
module tb_hysteresis_relay_controller;
  import hrc_pkg::*;

  localparam int     GROUP         = SAMPLES_DEFAULT;
  localparam int     TICK_SAT      = (1 << TICK_W) - 1;
  localparam int     DWELL_MAX     = (1 << DWELL_W) - 1;
  localparam int     BAND_MAX      = (1 << BAND_W) - 1;
  localparam int     GAIN_MAX      = (1 << (GAIN_W - 1)) - 1;
  localparam int     GAIN_MIN      = -(1 << (GAIN_W - 1));
  localparam int     GAIN_UNITY    = 256;
  localparam int     IDLE_PCT      = 37;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     FLUSH_LIMIT   = 20000;
  localparam int     MAX_REPORTS   = 10;
  localparam int     RANDOM_PHASES = 8;
  localparam int     PHASE_ITEMS   = 110;
  localparam int     QUIET_PHASE   = 3;
  localparam int     BURST_DWELL   = 32;
  localparam longint RUN_LIMIT     = 64'd60_000_000;

  typedef struct {
    logic                    relay_on;
    logic                    switched;
    logic signed [CAL_W-1:0] cal;
  } decision_t;

  logic                    clk;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic                    in_func       = FUNC_SAMPLE;
  logic [ADC_W-1:0]        in_adc_sample = '0;
  logic                    out_valid;
  logic                    out_stall     = 1'b0;
  logic                    out_relay_on;
  logic                    out_switched;
  logic signed [CAL_W-1:0] out_calibrated_value;
  logic                    cfg_valid     = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index     = CFG_SETPOINT;
  logic [CFG_DATA_W-1:0]   cfg_data      = '0;

  hysteresis_relay_controller #(.SAMPLES_PER_DECISION(GROUP)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_adc_sample        (in_adc_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_relay_on         (out_relay_on),
    .out_switched         (out_switched),
    .out_calibrated_value (out_calibrated_value),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Mirror of the controller: register file, sample accumulator, relay and dwell timer.
  logic signed [CAL_W-1:0]  mdl_setpoint;
  logic        [BAND_W-1:0] mdl_upper_band;
  logic        [BAND_W-1:0] mdl_lower_band;
  logic                     mdl_direct;
  logic        [DWELL_W-1:0] mdl_dwell;
  logic signed [GAIN_W-1:0] mdl_gain;
  logic signed [CAL_W-1:0]  mdl_offset;
  logic                     mdl_init_relay;
  int unsigned              acc_count;
  int unsigned              acc_total;
  logic                     relay_now;
  int unsigned              ticks_elapsed;

  // Decisions predicted at input transfer, retired in order by the result monitor.
  decision_t pending_decisions[$];

  // When set, neither side inserts bubbles or stalls.
  bit steady_flow = 1'b0;

  int errors         = 0;
  int items_sent     = 0;
  int ticks_sent     = 0;
  int decisions_seen = 0;
  int switches_seen  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs.
  initial begin
    #(RUN_LIMIT);
    $display("Timeout: %0d decisions still pending", pending_decisions.size());
    $display("tb_hysteresis_relay_controller NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    mdl_setpoint   = '0;
    mdl_upper_band = '0;
    mdl_lower_band = '0;
    mdl_direct     = 1'b1;
    mdl_dwell      = '0;
    mdl_gain       = GAIN_W'(GAIN_UNITY);
    mdl_offset     = '0;
    mdl_init_relay = 1'b0;
    acc_count      = 0;
    acc_total      = 0;
    relay_now      = 1'b0;
    ticks_elapsed  = 0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SETPOINT:      mdl_setpoint   = data[CAL_W-1:0];
      CFG_UPPER_BAND:    mdl_upper_band = data[BAND_W-1:0];
      CFG_LOWER_BAND:    mdl_lower_band = data[BAND_W-1:0];
      CFG_DIRECT_MODE:   mdl_direct     = data[0];
      CFG_MIN_DWELL:     mdl_dwell      = data[DWELL_W-1:0];
      CFG_GAIN:          mdl_gain       = data[GAIN_W-1:0];
      CFG_OFFSET:        mdl_offset     = data[CAL_W-1:0];
      CFG_INITIAL_RELAY: begin
        // load the relay at once; leave the timer and the accumulator alone
        mdl_init_relay = data[0];
        relay_now      = data[0];
      end
      default: ;
    endcase
  endfunction

  // gain * total / GROUP, rounded half away from zero, plus offset, saturated.
  function automatic logic signed [CAL_W-1:0] calibrate_total(int unsigned total);
    longint prod;
    longint quot;
    longint val;
    prod = longint'(mdl_gain) * longint'(total);
    if (prod < 0) quot = -((-prod + GROUP / 2) / GROUP);
    else          quot = (prod + GROUP / 2) / GROUP;
    val = quot + longint'(mdl_offset);
    if (val > CAL_MAX) val = CAL_MAX;
    if (val < CAL_MIN) val = CAL_MIN;
    return val[CAL_W-1:0];
  endfunction

  function automatic void predict_item(logic func, logic [ADC_W-1:0] adc);
    logic signed [CAL_W-1:0] cal;
    longint    v;
    longint    low_th;
    longint    high_th;
    logic      flip;
    decision_t d;
    if (func == FUNC_TICK) begin
      if (ticks_elapsed < TICK_SAT) ticks_elapsed++;
      return;
    end
    acc_total += adc;
    acc_count++;
    if (acc_count < GROUP) return;
    cal     = calibrate_total(acc_total);
    v       = cal;
    low_th  = longint'(mdl_setpoint) - longint'(mdl_lower_band);
    high_th = longint'(mdl_setpoint) + longint'(mdl_upper_band);
    flip    = 1'b0;
    if (ticks_elapsed > mdl_dwell) begin
      if (mdl_direct) flip = relay_now ? (v >= high_th) : (v <= low_th);
      else            flip = relay_now ? (v <= low_th) : (v >= high_th);
    end
    if (flip) begin
      relay_now     = ~relay_now;
      ticks_elapsed = 0;
    end
    d.relay_on = relay_now;
    d.switched = flip;
    d.cal      = cal;
    pending_decisions.push_back(d);
    acc_total = 0;
    acc_count = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall and in-order check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
  end

  function automatic void flag_error(string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    decision_t want;
    if (rst_n && out_valid && !out_stall) begin
      decisions_seen++;
      if (out_switched) switches_seen++;
      if (pending_decisions.size() == 0) begin
        flag_error($sformatf("unexpected result relay=%0b switched=%0b value=%0d",
                             out_relay_on, out_switched, out_calibrated_value));
      end else begin
        want = pending_decisions.pop_front();
        if (out_relay_on !== want.relay_on || out_switched !== want.switched ||
            out_calibrated_value !== want.cal) begin
          flag_error($sformatf({"decision %0d: expected relay=%0b switched=%0b value=%0d,",
                                " got relay=%0b switched=%0b value=%0d"},
                               decisions_seen, want.relay_on, want.switched, want.cal,
                               out_relay_on, out_switched, out_calibrated_value));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one item, with random bubbles ahead of it, and hold it until the transfer.
  task automatic send_item(logic func, logic [ADC_W-1:0] adc);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_adc_sample <= adc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(func, adc);
    items_sent++;
    if (func == FUNC_TICK) ticks_sent++;
  endtask

  // Ticks carry a random reading that the block must ignore.
  task automatic send_ticks(int count);
    repeat (count) send_item(FUNC_TICK, ADC_W'($urandom));
  endtask

  // One full decision group: the first reading, then GROUP-1 copies of another.
  task automatic send_group(logic [ADC_W-1:0] first, logic [ADC_W-1:0] rest);
    send_item(FUNC_SAMPLE, first);
    repeat (GROUP - 1) send_item(FUNC_SAMPLE, rest);
  endtask

  // Drop valid, wait for every pending decision, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: no switch before the first tick, then both directions at zero setpoint.
  task automatic test_power_on_defaults();
    send_group('0, '0);
    send_ticks(1);
    send_group('0, '0);
    send_ticks(1);
    send_group(ADC_MAX, ADC_MAX);
  endtask

  // Gain and offset at their limits, saturation both ways, rounding of halves.
  task automatic test_calibration_limits();
    settle();
    write_reg(CFG_GAIN, CFG_DATA_W'(GAIN_MAX));
    send_group(ADC_MAX, ADC_MAX);
    settle();
    write_reg(CFG_GAIN, CFG_DATA_W'(GAIN_MIN));
    send_group(ADC_MAX, ADC_MAX);
    settle();
    write_reg(CFG_GAIN, CFG_DATA_W'(1));
    write_reg(CFG_OFFSET, CFG_DATA_W'(CAL_MAX));
    send_group(5, '0);
    settle();
    write_reg(CFG_GAIN, CFG_DATA_W'(-1));
    write_reg(CFG_OFFSET, '0);
    send_group(5, '0);
    send_group(4, '0);
    settle();
    write_reg(CFG_GAIN, CFG_DATA_W'(1));
    write_reg(CFG_OFFSET, CFG_DATA_W'(CAL_MIN));
    send_group('0, '0);
    settle();
    write_reg(CFG_GAIN, CFG_DATA_W'(GAIN_UNITY));
    write_reg(CFG_OFFSET, '0);
  endtask

  // Dwell is strict: exactly min_dwell ticks holds, one more lets the relay move.
  task automatic test_dwell_time();
    settle();
    write_reg(CFG_INITIAL_RELAY, '0);
    write_reg(CFG_MIN_DWELL, '0);
    send_ticks(1);
    send_group('0, '0);
    settle();
    write_reg(CFG_MIN_DWELL, CFG_DATA_W'(3));
    send_ticks(3);
    send_group(ADC_MAX, ADC_MAX);
    send_ticks(1);
    send_group(ADC_MAX, ADC_MAX);
  endtask

  // Reverse mode turns on at the upper threshold and off at the lower, equality included.
  task automatic test_reverse_mode();
    settle();
    write_reg(CFG_MIN_DWELL, '0);
    write_reg(CFG_DIRECT_MODE, '0);
    write_reg(CFG_SETPOINT, CFG_DATA_W'(GAIN_UNITY * 500));
    write_reg(CFG_UPPER_BAND, CFG_DATA_W'(GAIN_UNITY * 100));
    write_reg(CFG_LOWER_BAND, CFG_DATA_W'(GAIN_UNITY * 100));
    write_reg(CFG_INITIAL_RELAY, '0);
    send_ticks(1);
    send_group(599, 599);
    send_group(600, 600);
    send_ticks(1);
    send_group(401, 401);
    send_group(400, 400);
    settle();
    write_reg(CFG_DIRECT_MODE, CFG_DATA_W'(1));
  endtask

  // Preload the relay and change gain in the middle of a group; the group keeps summing.
  task automatic test_relay_preload();
    settle();
    write_reg(CFG_INITIAL_RELAY, CFG_DATA_W'(1));
    repeat (4) send_item(FUNC_SAMPLE, 100);
    settle();
    write_reg(CFG_INITIAL_RELAY, '0);
    write_reg(CFG_GAIN, CFG_DATA_W'(2 * GAIN_UNITY));
    repeat (GROUP - 4) send_item(FUNC_SAMPLE, 900);
    send_ticks(2);
    send_group(ADC_MAX, '0);
    settle();
    write_reg(CFG_GAIN, CFG_DATA_W'(GAIN_UNITY));
  endtask

  // Writes to unmapped indexes must leave every register as it was.
  task automatic test_unmapped_index();
    settle();
    for (int idx = int'(CFG_INITIAL_RELAY) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    end
    send_ticks(1);
    send_group(ADC_MAX / 2, 0);
    send_group(0, ADC_MAX);
  endtask

  // Full-rate tick bursts against a long dwell: the dwell count itself holds the relay,
  // one more tick lets it move.
  task automatic test_tick_burst();
    settle();
    steady_flow = 1'b1;
    write_reg(CFG_SETPOINT, '0);
    write_reg(CFG_UPPER_BAND, '0);
    write_reg(CFG_LOWER_BAND, '0);
    write_reg(CFG_INITIAL_RELAY, '0);
    write_reg(CFG_MIN_DWELL, CFG_DATA_W'(BURST_DWELL));
    send_ticks(BURST_DWELL + 1);
    send_group('0, '0);
    send_ticks(BURST_DWELL);
    send_group(ADC_MAX, ADC_MAX);
    send_ticks(1);
    send_group(ADC_MAX, ADC_MAX);
    settle();
    write_reg(CFG_MIN_DWELL, '0);
    steady_flow = 1'b0;
  endtask

  // Phase 1 takes every register at its top, phase 2 at its bottom; later phases mix
  // extremes with values that keep readings near the thresholds.
  function automatic int pick_value(int phase, int lo, int hi, int typ_lo, int typ_hi);
    int roll;
    roll = $urandom_range(99);
    if (phase == 1 || (phase > 2 && roll < 12)) return hi;
    if (phase == 2 || (phase > 2 && roll < 24)) return lo;
    return typ_lo + int'($urandom_range(typ_hi - typ_lo));
  endfunction

  task automatic program_phase(int phase);
    write_reg(CFG_SETPOINT,
              CFG_DATA_W'(pick_value(phase, CAL_MIN, CAL_MAX, 0, 262000)));
    write_reg(CFG_UPPER_BAND, CFG_DATA_W'(pick_value(phase, 0, BAND_MAX, 0, 25000)));
    write_reg(CFG_LOWER_BAND, CFG_DATA_W'(pick_value(phase, 0, BAND_MAX, 0, 25000)));
    write_reg(CFG_DIRECT_MODE, CFG_DATA_W'(pick_value(phase, 0, 1, 0, 1)));
    write_reg(CFG_MIN_DWELL, CFG_DATA_W'(pick_value(phase, 0, DWELL_MAX, 0, 12)));
    write_reg(CFG_GAIN, CFG_DATA_W'(pick_value(phase, GAIN_MIN, GAIN_MAX, 128, 512)));
    write_reg(CFG_OFFSET, CFG_DATA_W'(pick_value(phase, CAL_MIN, CAL_MAX, -8192, 8192)));
    write_reg(CFG_INITIAL_RELAY, CFG_DATA_W'(pick_value(phase, 0, 1, 0, 1)));
  endtask

  // Groups of readings clustered around a random level, ticks sprinkled between them,
  // and now and then a partial group left open across the next register update.
  task automatic test_random_phases();
    int sent;
    int level;
    int reading;
    int burst;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      program_phase(phase);
      steady_flow = (phase == QUIET_PHASE);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        level = $urandom_range(ADC_MAX);
        for (int j = 0; j < GROUP; j++) begin
          if ($urandom_range(99) < 20) begin
            burst = $urandom_range(1, 3);
            send_ticks(burst);
            sent += burst;
          end
          if ($urandom_range(99) < 15) reading = $urandom_range(ADC_MAX);
          else reading = level + int'($urandom_range(64)) - 32;
          if (reading < 0) reading = 0;
          if (reading > ADC_MAX) reading = ADC_MAX;
          send_item(FUNC_SAMPLE, ADC_W'(reading));
          sent++;
        end
      end
      // leave a partial group open now and then
      if ($urandom_range(99) < 40) begin
        repeat ($urandom_range(1, GROUP - 1))
          send_item(FUNC_SAMPLE, ADC_W'($urandom_range(ADC_MAX)));
      end
      steady_flow = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_model();
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_defaults();
    test_calibration_limits();
    test_dwell_time();
    test_reverse_mode();
    test_relay_preload();
    test_unmapped_index();
    test_tick_burst();
    test_random_phases();

    // Drain what is left, bounded, then give the pipeline its latency once more.
    in_valid <= 1'b0;
    for (int i = 0; i < FLUSH_LIMIT && pending_decisions.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_decisions.size() != 0)
      flag_error($sformatf("%0d decisions never arrived", pending_decisions.size()));

    $display("Run covered %0d input transfers (%0d ticks), %0d decisions, %0d relay switches.",
             items_sent, ticks_sent, decisions_seen, switches_seen);
    $display("Register sweeps: defaults, saturation, rounding, dwell, reverse mode, %0d phases.",
             RANDOM_PHASES);
    if (errors == 0) begin
      $display("tb_hysteresis_relay_controller OK");
    end else begin
      $display("%0d errors", errors);
      $display("tb_hysteresis_relay_controller NOT OK");
    end
    $finish;
  end

endmodule

[hysteresis_relay_controller.f]
rtl/hrc_pkg.sv
rtl/hrc_front.sv
rtl/hrc_queue.sv
rtl/hrc_back.sv
rtl/hysteresis_relay_controller.sv
dv/tb_hysteresis_relay_controller.sv
